FILE: hdl/assert_macros.svh
// assertion macros used by the tag chunk parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define STCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in this cycle implies a condition in the next cycle
`define STCP_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define STCP_ASSERT(label, prop, msg)
`define STCP_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

FILE: hdl/stcp_pkg.sv
// types, constants and helper functions of the tag chunk parser
package stcp_pkg;

    localparam logic [15:0] MIN_TEXT_LENGTH = 16'd4;
    localparam logic [15:0] MAX_TEXT_LENGTH = 16'd256;
    localparam logic [7:0]  TRACK_MAX       = 8'd99;
    localparam logic [7:0]  CHAR_LOW        = 8'd32;
    localparam logic [7:0]  CHAR_HIGH       = 8'd127;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SUBHDR,
        PH_TEXT,
        PH_WORD,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_TEXT,
        KIND_END,
        KIND_ERR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_MAGIC,
        ERR_UNKNOWN_ID,
        ERR_TEXT_LENGTH,
        ERR_INLINE
    } err_t;

    typedef enum logic [2:0] {
        CL_UNKNOWN,
        CL_TEXT,
        CL_WORD,
        CL_LOW,
        CL_FULL,
        CL_TRACK
    } class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } byte_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tag_id;
        logic [31:0] value;
        logic        text_last;
        logic        chunk_done;
        err_t        error_code;
    } result_word_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  hdr_idx;
        logic [31:0] chunk_len;
        logic [31:0] consumed;
        logic [7:0]  cur_id;
        logic [7:0]  cur_type;
        logic [15:0] cur_len;
        logic [16:0] remaining;
        logic [31:0] word_acc;
    } state_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h78;
            2'd1:    b = 8'h69;
            2'd2:    b = 8'h64;
            default: b = 8'h36;
        endcase
        return b;
    endfunction

    function automatic class_t classify(input logic [7:0] id);
        class_t cl;
        unique case (id) inside
            8'h01, 8'h02, 8'h03, 8'h04, 8'h07, 8'h10, 8'h13: cl = CL_TEXT;
            8'h05, 8'h30, 8'h31, 8'h32, 8'h33, 8'h36:        cl = CL_WORD;
            8'h06, 8'h34, 8'h35:                             cl = CL_LOW;
            8'h11, 8'h14:                                    cl = CL_FULL;
            8'h12:                                           cl = CL_TRACK;
            default:                                         cl = CL_UNKNOWN;
        endcase
        return cl;
    endfunction

    // data length rounded up to a multiple of four
    function automatic logic [16:0] span_of(input logic [15:0] len);
        logic [1:0] pad;
        pad = 2'd0 - len[1:0];
        return {1'b0, len} + {15'd0, pad};
    endfunction

endpackage

FILE: hdl/stcp_step.sv
// per-byte next state and result logic of the tag chunk parser
module stcp_step
    import stcp_pkg::*;
(
    input  state_t       cur,
    input  byte_word_t   in_word,
    output state_t       nxt,
    output logic         res_valid,
    output result_word_t res
);

    state_t      s;
    logic [7:0]  b;
    logic [31:0] bc_inc;
    logic        end_hit;
    logic [16:0] rem_dec;
    logic        rem_zero;
    logic [31:0] hdr_len;
    logic [15:0] len_new;
    logic [16:0] span_new;
    class_t      cl;
    logic        text_len_bad;
    logic [7:0]  trk_no;
    logic [7:0]  trk_ch;
    logic [15:0] num_val;
    logic [16:0] text_idx;
    logic [16:0] text_idx_inc;
    logic        text_has;
    logic        text_last;
    logic [31:0] word_val;

    // a first byte restarts from the reset state
    always_comb
    begin
        s = cur;
        if (in_word.first_byte)
        begin
            s       = '0;
            s.phase = PH_HEADER;
        end
    end

    assign b        = in_word.data_byte;
    assign bc_inc   = (s.consumed == '1) ? s.consumed : s.consumed + 32'd1;
    assign end_hit  = (bc_inc >= s.chunk_len);
    assign rem_dec  = s.remaining - 17'd1;
    assign rem_zero = (rem_dec == '0);
    assign hdr_len  = s.chunk_len | ({24'd0, b} << {s.hdr_idx[1:0], 3'b000});
    assign len_new  = {b, s.cur_len[7:0]};
    assign span_new = (s.cur_type != '0) ? span_of(len_new) : '0;
    assign cl       = classify(s.cur_id);

    assign text_len_bad = (len_new < MIN_TEXT_LENGTH) || (len_new > MAX_TEXT_LENGTH);

    assign trk_no = (b > TRACK_MAX) ? 8'd0 : b;
    assign trk_ch = (s.cur_len[7:0] > CHAR_LOW && s.cur_len[7:0] < CHAR_HIGH)
                    ? s.cur_len[7:0] : 8'd0;

    always_comb
    begin
        case (cl)
            CL_LOW:   num_val = {8'd0, s.cur_len[7:0]};
            CL_FULL:  num_val = len_new;
            default:  num_val = {trk_no, trk_ch};
        endcase
    end

    assign text_idx     = span_of(s.cur_len) - s.remaining;
    assign text_idx_inc = text_idx + 17'd1;
    assign text_has     = (text_idx < {1'b0, s.cur_len});
    assign text_last    = (text_idx_inc == {1'b0, s.cur_len});
    assign word_val     = s.word_acc | ({24'd0, b} << {s.hdr_idx[1:0], 3'b000});

    // next state
    always_comb
    begin
        nxt = s;
        unique case (s.phase)
            PH_HEADER:
            begin
                if (s.hdr_idx < 3'd4)
                begin
                    if (b != magic_byte(s.hdr_idx[1:0]))
                        nxt.phase = PH_IDLE;
                    else
                        nxt.hdr_idx = s.hdr_idx + 3'd1;
                end
                else
                begin
                    nxt.chunk_len = hdr_len;
                    if (s.hdr_idx == 3'd7)
                    begin
                        nxt.hdr_idx = '0;
                        nxt.phase   = (hdr_len == '0) ? PH_IDLE : PH_SUBHDR;
                    end
                    else
                        nxt.hdr_idx = s.hdr_idx + 3'd1;
                end
            end
            PH_SUBHDR:
            begin
                nxt.consumed = bc_inc;
                unique case (s.hdr_idx[1:0])
                    2'd0:
                    begin
                        nxt.cur_id  = b;
                        nxt.hdr_idx = s.hdr_idx + 3'd1;
                    end
                    2'd1:
                    begin
                        nxt.cur_type = b;
                        nxt.hdr_idx  = s.hdr_idx + 3'd1;
                    end
                    2'd2:
                    begin
                        nxt.cur_len = {8'd0, b};
                        nxt.hdr_idx = s.hdr_idx + 3'd1;
                    end
                    default:
                    begin
                        nxt.cur_len = len_new;
                        nxt.hdr_idx = '0;
                        case (cl)
                            CL_UNKNOWN:
                                nxt.phase = PH_IDLE;
                            CL_TEXT:
                            begin
                                if (text_len_bad || s.cur_type == '0)
                                    nxt.phase = PH_IDLE;
                                else
                                begin
                                    nxt.remaining = span_new;
                                    nxt.phase     = PH_TEXT;
                                end
                            end
                            CL_WORD:
                            begin
                                if (s.cur_type == '0)
                                    nxt.phase = PH_IDLE;
                                else
                                begin
                                    nxt.word_acc  = '0;
                                    nxt.remaining = span_new;
                                    if (span_new == '0)
                                        nxt.phase = end_hit ? PH_IDLE : PH_SUBHDR;
                                    else
                                        nxt.phase = PH_WORD;
                                end
                            end
                            default:
                            begin
                                nxt.remaining = span_new;
                                if (span_new == '0)
                                    nxt.phase = end_hit ? PH_IDLE : PH_SUBHDR;
                                else
                                    nxt.phase = PH_SKIP;
                            end
                        endcase
                    end
                endcase
            end
            PH_TEXT, PH_WORD, PH_SKIP:
            begin
                nxt.consumed  = bc_inc;
                nxt.remaining = rem_dec;
                if (s.phase == PH_WORD && s.hdr_idx < 3'd4)
                begin
                    nxt.word_acc = word_val;
                    nxt.hdr_idx  = s.hdr_idx + 3'd1;
                end
                if (rem_zero)
                begin
                    nxt.hdr_idx = '0;
                    nxt.phase   = end_hit ? PH_IDLE : PH_SUBHDR;
                end
            end
            default:
                nxt = s;
        endcase
    end

    // result
    always_comb
    begin
        res_valid      = 1'b0;
        res.kind       = KIND_NUM;
        res.tag_id     = nxt.cur_id;
        res.value      = '0;
        res.text_last  = 1'b0;
        res.chunk_done = 1'b0;
        res.error_code = ERR_NONE;
        unique case (s.phase)
            PH_HEADER:
            begin
                if (s.hdr_idx < 3'd4)
                begin
                    if (b != magic_byte(s.hdr_idx[1:0]))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERR;
                        res.error_code = ERR_BAD_MAGIC;
                    end
                end
                else if (s.hdr_idx == 3'd7 && hdr_len == '0)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_END;
                    res.chunk_done = 1'b1;
                end
            end
            PH_SUBHDR:
            begin
                if (s.hdr_idx[1:0] == 2'd3)
                begin
                    case (cl)
                        CL_UNKNOWN:
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERR;
                            res.error_code = ERR_UNKNOWN_ID;
                        end
                        CL_TEXT:
                        begin
                            if (text_len_bad)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERR;
                                res.error_code = ERR_TEXT_LENGTH;
                            end
                            else if (s.cur_type == '0)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERR;
                                res.error_code = ERR_INLINE;
                            end
                        end
                        CL_WORD:
                        begin
                            if (s.cur_type == '0)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERR;
                                res.error_code = ERR_INLINE;
                            end
                            else if (span_new == '0)
                            begin
                                res_valid      = 1'b1;
                                res.chunk_done = end_hit;
                            end
                        end
                        default:
                        begin
                            res_valid      = 1'b1;
                            res.value      = {16'd0, num_val};
                            res.chunk_done = (span_new == '0) && end_hit;
                        end
                    endcase
                end
            end
            PH_TEXT:
            begin
                if (text_has)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_TEXT;
                    res.value      = {24'd0, b};
                    res.text_last  = text_last;
                    res.chunk_done = rem_zero && end_hit;
                end
                else if (rem_zero && end_hit)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_END;
                    res.chunk_done = 1'b1;
                end
            end
            PH_WORD:
            begin
                if (s.hdr_idx == 3'd3)
                begin
                    res_valid      = 1'b1;
                    res.value      = word_val;
                    res.chunk_done = rem_zero && end_hit;
                end
                else if (rem_zero && end_hit)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_END;
                    res.chunk_done = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (rem_zero && end_hit)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_END;
                    res.chunk_done = 1'b1;
                end
            end
            default:
                res_valid = 1'b0;
        endcase
    end

endmodule

FILE: hdl/sound_tag_chunk_parser_core.sv
// top level of the tag chunk parser: state registers and result register
// Takes an extended tag chunk one byte per word, starting at its "xid6"
// magic byte (first_byte=1, which also restarts the parser anywhere). It
// reads the 32-bit little-endian body length, then walks 4-byte sub-chunk
// headers and their data padded to four bytes, and gives at most one result
// word per byte: a numeric tag, a text byte (text_last on the final one), a
// chunk end, or an error. After chunk end or any error, bytes are dropped
// until the next first byte. Every byte is handled in the cycle it is
// accepted, so one byte per clock is taken as long as the result side keeps
// up; a byte is held off only while a finished result word sits in the
// output register and the result side stalls. Each result is registered and
// seen in the cycle after its byte. There is no configuration and no memory.
`include "assert_macros.svh"

module sound_tag_chunk_parser_core
    import stcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // byte channel
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_word_t   byte_word,
    // result channel
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result_word
);

    state_t       state_reg;
    state_t       state_next;
    logic         step_valid;
    result_word_t step_result;
    logic         result_valid_reg;
    result_word_t result_reg;
    logic         byte_accept;

    // hold off bytes only while the result register is full and stalled
    assign byte_stall  = result_valid_reg && result_stall;
    assign byte_accept = byte_valid && !byte_stall;

    stcp_step u_step (
        .cur       (state_reg),
        .in_word   (byte_word),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_result)
    );

    // parser state moves only on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (byte_accept)
            state_reg <= state_next;
    end

    // result register: refilled on accept, emptied when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (byte_accept)
            result_valid_reg <= step_valid;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && step_valid)
            result_reg <= step_result;
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

    // any error drops the parser to idle
    `STCP_ASSERT_NEXT(a_err_idle, byte_accept && step_valid && step_result.kind == KIND_ERR, state_reg.phase == PH_IDLE, "error did not return to idle")
    // a completed chunk drops the parser to idle
    `STCP_ASSERT_NEXT(a_done_idle, byte_accept && step_valid && step_result.chunk_done, state_reg.phase == PH_IDLE, "chunk end did not return to idle")
    // text_last only on text bytes
    `STCP_ASSERT(a_last_text, !(result_valid_reg && result_reg.text_last) || result_reg.kind == KIND_TEXT, "text_last on non-text result")
    // errors never carry chunk_done
    `STCP_ASSERT(a_err_nodone, !(result_valid_reg && result_reg.kind == KIND_ERR) || !result_reg.chunk_done, "error marked chunk_done")
    // sub-chunk header index stays within a header
    `STCP_ASSERT(a_hdr_range, state_reg.phase != PH_SUBHDR || state_reg.hdr_idx < 3'd4, "header index out of range")

endmodule

FILE: sim/testbench.sv
// self-checking testbench for sound_tag_chunk_parser_core: directed script, random chunks
module testbench
    import stcp_pkg::*;
();

    // magic that opens every chunk, in stream order
    localparam logic [7:0] MAGIC [4] = '{8'h78, 8'h69, 8'h64, 8'h36};

    // tag ids grouped by how their value is reported
    localparam logic [7:0] TEXT_IDS [7] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h07, 8'h10, 8'h13};
    localparam logic [7:0] WORD_IDS [6] = '{8'h05, 8'h30, 8'h31, 8'h32, 8'h33, 8'h36};
    localparam logic [7:0] INLINE_IDS [6] = '{8'h06, 8'h34, 8'h35, 8'h11, 8'h14, 8'h12};
    localparam logic [7:0] TRACK_ID = 8'h12;

    // accepted byte count that ends the random part
    localparam int STOP_ITEMS = 435;
    localparam int MID_PAUSE_ITEMS = 200;

    // one line of the directed script; a pinned line carries its result word
    typedef struct {
        logic [7:0]   data;
        logic         first;
        bit           pinned;
        result_word_t want;
    } script_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_stall;
    byte_word_t   byte_word = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result_word;

    // walker state, kept apart from the block and updated on every accepted byte
    phase_t      walk_phase;
    logic [2:0]  walk_hdr;
    logic [31:0] walk_chunk_len;
    logic [31:0] walk_consumed;
    logic [7:0]  walk_id;
    logic [7:0]  walk_type;
    logic [15:0] walk_len;
    logic [16:0] walk_left;
    logic [31:0] walk_word;

    // result words still owed by the block, oldest first
    result_word_t pending_results [$];

    // sub-chunk bytes of the chunk being built
    logic [7:0] chunk_body [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  bytes_sent = 0;
    int  live_items = 0;
    int  chunks_started = 0;
    int  kind_seen [4];
    int  code_seen [5];
    bit  sender_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  rx_words = 0;

    script_row_t script [25] = '{
        // a byte before any chunk is opened is dropped
        '{8'h00, 1'b0, 1'b0, '0},
        // magic broken at its second byte, then a dropped byte
        '{8'h78, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{KIND_ERR, 8'h00, 32'h0, 1'b0, 1'b0, ERR_BAD_MAGIC}},
        '{8'hFF, 1'b0, 1'b0, '0},
        // zero body length ends the chunk on the last length byte
        '{8'h78, 1'b1, 1'b0, '0},
        '{8'h69, 1'b0, 1'b0, '0},
        '{8'h64, 1'b0, 1'b0, '0},
        '{8'h36, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{KIND_END, 8'h00, 32'h0, 1'b0, 1'b1, ERR_NONE}},
        // four-byte body holding one inline track tag: number 100 zeroed, 'c' kept
        '{8'h78, 1'b1, 1'b0, '0},
        '{8'h69, 1'b0, 1'b0, '0},
        '{8'h64, 1'b0, 1'b0, '0},
        '{8'h36, 1'b0, 1'b0, '0},
        '{8'h04, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h63, 1'b0, 1'b0, '0},
        '{8'h64, 1'b0, 1'b1, '{KIND_NUM, 8'h12, 32'h63, 1'b0, 1'b1, ERR_NONE}},
        // restart left hanging in the header, picked up by the random part
        '{8'h78, 1'b1, 1'b0, '0}
    };

    sound_tag_chunk_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_word   (byte_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_word (result_word)
    );

    // period of two
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // data length rounded up to whole four-byte groups
    function automatic logic [16:0] padded_len(input logic [15:0] n);
        return ({1'b0, n} + 17'd3) & 17'h1FFFC;
    endfunction

    function automatic class_t tag_class(input logic [7:0] id);
        foreach (TEXT_IDS[i])
            if (TEXT_IDS[i] == id)
                return CL_TEXT;
        foreach (WORD_IDS[i])
            if (WORD_IDS[i] == id)
                return CL_WORD;
        if (id == 8'h06 || id == 8'h34 || id == 8'h35)
            return CL_LOW;
        if (id == 8'h11 || id == 8'h14)
            return CL_FULL;
        if (id == TRACK_ID)
            return CL_TRACK;
        return CL_UNKNOWN;
    endfunction

    function automatic void reset_walker();
        walk_phase = PH_IDLE;
        walk_hdr = '0;
        walk_chunk_len = '0;
        walk_consumed = '0;
        walk_id = '0;
        walk_type = '0;
        walk_len = '0;
        walk_left = '0;
        walk_word = '0;
    endfunction

    function automatic result_word_t result_of(input kind_t k, input logic [31:0] v,
                                               input bit last, input bit done, input err_t e);
        result_word_t r;
        r.kind = k;
        r.tag_id = walk_id;
        r.value = v;
        r.text_last = last;
        r.chunk_done = done;
        r.error_code = e;
        return r;
    endfunction

    // any error drops the walker back to idle
    function automatic result_word_t abort_with(input err_t e);
        walk_phase = PH_IDLE;
        return result_of(KIND_ERR, 32'd0, 1'b0, 1'b0, e);
    endfunction

    // body bytes count up and stick at the top
    function automatic void count_body();
        if (walk_consumed != '1)
            walk_consumed++;
    endfunction

    // sub-chunk boundary: the chunk closes once the declared body is used up
    function automatic bit chunk_finished();
        walk_hdr = '0;
        if (walk_consumed >= walk_chunk_len)
        begin
            walk_phase = PH_IDLE;
            return 1'b1;
        end
        walk_phase = PH_SUBHDR;
        return 1'b0;
    endfunction

    // last header byte in: decide what the sub-chunk reports and what follows it
    function automatic void close_header(output bit got, output result_word_t r);
        class_t      cl;
        logic [16:0] span;
        logic [31:0] v;
        logic [7:0]  no;
        logic [7:0]  ch;
        bit          done;
        got = 1'b0;
        r = '0;
        cl = tag_class(walk_id);
        span = (walk_type != 8'd0) ? padded_len(walk_len) : 17'd0;
        case (cl)
            CL_UNKNOWN:
            begin
                got = 1'b1;
                r = abort_with(ERR_UNKNOWN_ID);
            end
            CL_TEXT:
            begin
                if (walk_len < MIN_TEXT_LENGTH || walk_len > MAX_TEXT_LENGTH)
                begin
                    got = 1'b1;
                    r = abort_with(ERR_TEXT_LENGTH);
                end
                else if (walk_type == 8'd0)
                begin
                    got = 1'b1;
                    r = abort_with(ERR_INLINE);
                end
                else
                begin
                    walk_left = span;
                    walk_phase = PH_TEXT;
                end
            end
            CL_WORD:
            begin
                if (walk_type == 8'd0)
                begin
                    got = 1'b1;
                    r = abort_with(ERR_INLINE);
                end
                else
                begin
                    walk_word = '0;
                    walk_left = span;
                    walk_hdr = '0;
                    if (span == 17'd0)
                    begin
                        done = chunk_finished();
                        got = 1'b1;
                        r = result_of(KIND_NUM, 32'd0, 1'b0, done, ERR_NONE);
                    end
                    else
                        walk_phase = PH_WORD;
                end
            end
            default:
            begin
                if (cl == CL_LOW)
                    v = {24'd0, walk_len[7:0]};
                else if (cl == CL_FULL)
                    v = {16'd0, walk_len};
                else
                begin
                    no = walk_len[15:8];
                    ch = walk_len[7:0];
                    if (no > TRACK_MAX)
                        no = 8'd0;
                    if (!(ch > CHAR_LOW && ch < CHAR_HIGH))
                        ch = 8'd0;
                    v = {16'd0, no, ch};
                end
                walk_left = span;
                got = 1'b1;
                if (span == 17'd0)
                begin
                    done = chunk_finished();
                    r = result_of(KIND_NUM, v, 1'b0, done, ERR_NONE);
                end
                else
                begin
                    walk_phase = PH_SKIP;
                    r = result_of(KIND_NUM, v, 1'b0, 1'b0, ERR_NONE);
                end
            end
        endcase
    endfunction

    // one accepted byte: advance the walker and give the result word it causes, if any
    function automatic void parse_byte(input byte_word_t w, output bit got,
                                       output result_word_t r);
        logic [7:0]  b;
        logic [16:0] pos;
        bit          has;
        bit          done;
        b = w.data_byte;
        got = 1'b0;
        r = '0;
        if (w.first_byte)
        begin
            reset_walker();
            walk_phase = PH_HEADER;
        end
        case (walk_phase)
            PH_HEADER:
            begin
                if (walk_hdr < 3'd4)
                begin
                    if (b != MAGIC[walk_hdr[1:0]])
                    begin
                        got = 1'b1;
                        r = abort_with(ERR_BAD_MAGIC);
                    end
                    else
                        walk_hdr++;
                end
                else
                begin
                    walk_chunk_len |= 32'(b) << (8 * (walk_hdr - 3'd4));
                    if (walk_hdr == 3'd7)
                    begin
                        walk_hdr = '0;
                        walk_phase = PH_SUBHDR;
                        if (walk_chunk_len == 32'd0)
                        begin
                            walk_phase = PH_IDLE;
                            got = 1'b1;
                            r = result_of(KIND_END, 32'd0, 1'b0, 1'b1, ERR_NONE);
                        end
                    end
                    else
                        walk_hdr++;
                end
            end
            PH_SUBHDR:
            begin
                count_body();
                case (walk_hdr[1:0])
                    2'd0: walk_id = b;
                    2'd1: walk_type = b;
                    2'd2: walk_len = {8'd0, b};
                    default: walk_len[15:8] = b;
                endcase
                if (walk_hdr[1:0] == 2'd3)
                begin
                    walk_hdr = '0;
                    close_header(got, r);
                end
                else
                    walk_hdr++;
            end
            PH_TEXT:
            begin
                pos = padded_len(walk_len) - walk_left;
                has = pos < {1'b0, walk_len};
                count_body();
                walk_left--;
                done = (walk_left == 17'd0) ? chunk_finished() : 1'b0;
                if (has)
                begin
                    got = 1'b1;
                    r = result_of(KIND_TEXT, {24'd0, b}, pos + 17'd1 == {1'b0, walk_len},
                                  done, ERR_NONE);
                end
                else if (done)
                begin
                    got = 1'b1;
                    r = result_of(KIND_END, 32'd0, 1'b0, 1'b1, ERR_NONE);
                end
            end
            PH_WORD:
            begin
                has = 1'b0;
                count_body();
                if (walk_hdr < 3'd4)
                begin
                    walk_word |= 32'(b) << (8 * walk_hdr[1:0]);
                    walk_hdr++;
                    has = (walk_hdr == 3'd4);
                end
                walk_left--;
                done = (walk_left == 17'd0) ? chunk_finished() : 1'b0;
                if (has)
                begin
                    got = 1'b1;
                    r = result_of(KIND_NUM, walk_word, 1'b0, done, ERR_NONE);
                end
                else if (done)
                begin
                    got = 1'b1;
                    r = result_of(KIND_END, 32'd0, 1'b0, 1'b1, ERR_NONE);
                end
            end
            PH_SKIP:
            begin
                count_body();
                walk_left--;
                if (walk_left == 17'd0 && chunk_finished())
                begin
                    got = 1'b1;
                    r = result_of(KIND_END, 32'd0, 1'b0, 1'b1, ERR_NONE);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] seen,
                                 input logic [31:0] want);
        if (seen !== want)
            flag_mismatch($sformatf("result word %0d, %s is %h, expected %h",
                                    results_seen, name, seen, want));
    endtask

    task automatic check_result(input result_word_t seen);
        result_word_t want;
        if (pending_results.size() == 0)
        begin
            flag_mismatch($sformatf("result word %h with nothing expected", seen));
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        compare_field("kind", 32'(seen.kind), 32'(want.kind));
        compare_field("tag_id", 32'(seen.tag_id), 32'(want.tag_id));
        compare_field("value", seen.value, want.value);
        compare_field("text_last", 32'(seen.text_last), 32'(want.text_last));
        compare_field("chunk_done", 32'(seen.chunk_done), 32'(want.chunk_done));
        compare_field("error_code", 32'(seen.error_code), 32'(want.error_code));
        kind_seen[int'(want.kind)]++;
        if (want.kind == KIND_ERR)
            code_seen[int'(want.error_code)]++;
    endtask

    // drive one byte after a random gap, hold it through stalls, then predict its result
    task automatic send_byte(input logic [7:0] data, input logic first,
                             input bit pinned = 1'b0, input result_word_t want = '0);
        byte_word_t   w;
        int           gap;
        bit           got;
        result_word_t r;
        w.data_byte = data;
        w.first_byte = first;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_word <= w;
        do @(posedge clk); while (byte_stall);
        // bytes dropped by an idle parser do not count as parsed
        if (first || walk_phase != PH_IDLE)
            live_items++;
        bytes_sent++;
        parse_byte(w, got, r);
        if (pinned)
            pending_results.push_back(want);
        else if (got)
            pending_results.push_back(r);
    endtask

    // sender stops until every owed result word is back
    task automatic hold_until_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // one sub-chunk with random content, biased toward the id groups and their edge cases
    task automatic add_subchunk();
        int          pick;
        logic [7:0]  id;
        logic [7:0]  type_byte;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        type_byte = 8'($urandom_range(1, 255));
        if (pick < 30)
        begin
            // text tag: mostly short, now and then the length limits or a broken header
            id = TEXT_IDS[$urandom_range(0, 6)];
            len = 16'($urandom_range(4, 24));
            case ($urandom_range(0, 29))
                0: len = MAX_TEXT_LENGTH;
                1: len = MIN_TEXT_LENGTH;
                2: len = 16'($urandom_range(0, 3));
                3: len = 16'($urandom_range(257, 65535));
                4: type_byte = 8'h00;
                default: ;
            endcase
        end
        else if (pick < 50)
        begin
            // word tag, including an empty data area and short padded ones
            id = WORD_IDS[$urandom_range(0, 5)];
            len = 16'($urandom_range(0, 10));
            if ($urandom_range(0, 9) == 0)
                type_byte = 8'h00;
        end
        else if (pick < 80)
        begin
            // inline value, sometimes with a data area that gets skipped
            id = INLINE_IDS[$urandom_range(0, 5)];
            if ($urandom_range(0, 3) == 0)
                len = 16'($urandom_range(0, 12));
            else
            begin
                type_byte = 8'h00;
                len = 16'($urandom);
                if (id == TRACK_ID && $urandom_range(0, 1))
                    len = {8'($urandom_range(97, 101)),
                           $urandom_range(0, 1) ? 8'($urandom_range(31, 34))
                                                : 8'($urandom_range(125, 128))};
            end
        end
        else if (pick < 88)
        begin
            do id = 8'($urandom); while (tag_class(id) != CL_UNKNOWN);
            len = 16'($urandom);
        end
        else
        begin
            // anything at all in the header
            id = 8'($urandom);
            if ($urandom_range(0, 1))
                type_byte = 8'h00;
            len = (type_byte == 8'h00) ? 16'($urandom) : 16'($urandom_range(0, 12));
        end
        chunk_body.push_back(id);
        chunk_body.push_back(type_byte);
        chunk_body.push_back(len[7:0]);
        chunk_body.push_back(len[15:8]);
        if (type_byte != 8'h00 && len <= 16'd300)
            repeat (padded_len(len)) chunk_body.push_back(8'($urandom));
    endtask

    // one stretch of stimulus: line noise, a broken magic, or a whole chunk
    task automatic run_episode();
        int          pick;
        int          cut;
        logic [31:0] declared;
        pick = $urandom_range(0, 99);
        // some episodes go back to back with no gaps at all
        sender_burst = ($urandom_range(0, 3) == 0);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        else if (pick < 15)
        begin
            cut = $urandom_range(0, 3);
            for (int k = 0; k <= cut; k++)
                send_byte((k == cut) ? MAGIC[k] ^ 8'($urandom_range(1, 255)) : MAGIC[k],
                          k == 0);
        end
        else
        begin
            chunks_started++;
            chunk_body.delete();
            repeat ($urandom_range(0, 4)) add_subchunk();
            declared = chunk_body.size();
            case ($urandom_range(0, 19))
                // declared end falls inside the last sub-chunk
                0, 1: if (declared > 0) declared = declared - $urandom_range(1, 3);
                // body promised longer than sent
                2: declared = declared + $urandom_range(1, 8);
                3: declared = 32'hFFFF_FFFF;
                // chunk cut short, next first byte restarts mid-flight
                4, 5:
                begin
                    if (chunk_body.size() > 0)
                        repeat ($urandom_range(1, chunk_body.size()))
                            void'(chunk_body.pop_back());
                end
                default: ;
            endcase
            for (int k = 0; k < 4; k++)
                send_byte(MAGIC[k], k == 0);
            for (int k = 0; k < 4; k++)
                send_byte(declared[8 * k +: 8], 1'b0);
            foreach (chunk_body[i])
                send_byte(chunk_body[i], 1'b0);
            // trailing bytes are dropped once the chunk has closed
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    // every accepted result word is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
            check_result(result_word);
    end

    // result side: stall a random number of cycles before each word, with fast stretches
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_burst ? 0 : $urandom_range(0, 13);
            repeat (hold)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            rx_words++;
            if (rx_words % 40 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // hard limit, far above the slowest legal run
    initial
    begin
        #400000;
        $display("timeout with %0d result words still expected", pending_results.size());
        $display("sound_tag_chunk_parser_core verification failed");
        $finish;
    end

    initial
    begin
        bit paused_mid;
        paused_mid = 1'b0;
        reset_walker();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed script first
        foreach (script[i])
            send_byte(script[i].data, script[i].first, script[i].pinned, script[i].want);
        hold_until_drained();

        // random chunks, with one full drain partway through
        while (bytes_sent < STOP_ITEMS)
        begin
            run_episode();
            if (!paused_mid && bytes_sent >= MID_PAUSE_ITEMS)
            begin
                hold_until_drained();
                paused_mid = 1'b1;
            end
        end

        // wind down: nothing more to send, then wait for owed words
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d bytes (%0d parsed) over %0d chunks, %0d result words",
                 bytes_sent, live_items, chunks_started, results_seen);
        $display("numeric %0d, text %0d, chunk end %0d, errors %0d (magic %0d, id %0d, %s",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], code_seen[1],
                 code_seen[2], $sformatf("text length %0d, inline %0d)",
                                          code_seen[3], code_seen[4]));
        if (mismatch_count == 0)
            $display("sound_tag_chunk_parser_core verification clean");
        else
            $display("sound_tag_chunk_parser_core verification failed");
        $finish;
    end

endmodule
